// ===== sv/low_voltage_disconnect_control_defines.svh =====
// Assertion macros shared by the low voltage disconnect control RTL.
`ifndef LOW_VOLTAGE_DISCONNECT_CONTROL_DEFINES_SVH
`define LOW_VOLTAGE_DISCONNECT_CONTROL_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define LVDC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lvdc same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define LVDC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lvdc next-cycle check failed");

`endif

// ===== sv/lvdc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lvdc_pkg;

  // Register indexes, decoded from paddr[3:2].
  typedef enum logic [1:0] {
    REG_SHUTDOWN_LIMIT   = 2'd0,
    REG_LOW_READS_NEEDED = 2'd1,
    REG_PERIODS_NEEDED   = 2'd2,
    REG_PERIOD_MS        = 2'd3
  } reg_index_t;

  localparam logic [15:0] SHUTDOWN_LIMIT_RST   = 16'd0;
  localparam logic [7:0]  LOW_READS_NEEDED_RST = 8'd10;
  localparam logic [7:0]  PERIODS_NEEDED_RST   = 8'd6;
  localparam logic [15:0] PERIOD_MS_RST        = 16'd30000;

  localparam logic [7:0]  COUNT_MAX = 8'hFF;

endpackage

`default_nettype wire

// ===== sv/low_voltage_disconnect_control.sv =====
// A request passes through the input register and then the result register.
// Throughput: one request per cycle unless the result stream stalls; the state update
// is one pass through the compare and counter logic between the input and result registers.
// Reset (rst, synchronous, active high) clears all counters, the watch state,
// the timer, the shutdown latch and both valid flags, and loads register defaults.
`timescale 1ns / 1ps
`default_nettype none

`include "low_voltage_disconnect_control_defines.svh"

module low_voltage_disconnect_control (
  input  wire logic        clk,
  input  wire logic        rst,
  // APB-style configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  // Request stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // [15:0] voltage, [31:16] elapsed_ms
  // Result stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [15:0] m_tdata    // [0] shutdown_active, [1] low_confirmed,
                                      // [2] watching, [10:3] periods_counted, rest 0
);

  import lvdc_pkg::*;

  // Configuration registers
  logic [15:0] shutdown_limit;
  logic [7:0]  low_reads_needed;
  logic [7:0]  periods_needed;
  logic [15:0] period_ms;

  reg_index_t  cfg_sel;
  logic        cfg_write;

  // Input register
  logic        in_valid;
  logic [15:0] in_voltage;
  logic [15:0] in_elapsed;

  // Check state
  logic [7:0]  low_count,    low_count_next;
  logic        low_flag,     low_flag_next;
  logic        watch_state,  watch_state_next;
  logic [7:0]  period_count, period_count_next;
  logic [15:0] timer_left,   timer_left_next;
  logic        shutdown_latch, shutdown_latch_next;

  logic        out_free;
  logic        advance;

  logic [7:0]  low_inc;
  logic [7:0]  period_inc;
  logic [15:0] timer_dec;
  logic        is_high;

  assign pready    = 1'b1;
  assign cfg_sel   = reg_index_t'(paddr[3:2]);
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      shutdown_limit   <= SHUTDOWN_LIMIT_RST;
      low_reads_needed <= LOW_READS_NEEDED_RST;
      periods_needed   <= PERIODS_NEEDED_RST;
      period_ms        <= PERIOD_MS_RST;
    end else if (cfg_write) begin
      case (cfg_sel)
        REG_SHUTDOWN_LIMIT:   shutdown_limit   <= pwdata[15:0];
        REG_LOW_READS_NEEDED: low_reads_needed <= pwdata[7:0];
        REG_PERIODS_NEEDED:   periods_needed   <= pwdata[7:0];
        REG_PERIOD_MS:        period_ms        <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      REG_SHUTDOWN_LIMIT:   prdata = {16'd0, shutdown_limit};
      REG_LOW_READS_NEEDED: prdata = {24'd0, low_reads_needed};
      REG_PERIODS_NEEDED:   prdata = {24'd0, periods_needed};
      REG_PERIOD_MS:        prdata = {16'd0, period_ms};
      default:              prdata = 32'd0;
    endcase
  end

  // The input register moves on whenever the result register is free or being drained.
  assign out_free = !m_tvalid || m_tready;
  assign advance  = in_valid && out_free;
  assign s_tready = !in_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_voltage <= s_tdata[15:0];
      in_elapsed <= s_tdata[31:16];
    end
  end

  assign low_inc    = (low_count == COUNT_MAX) ? low_count : low_count + 8'd1;
  assign period_inc = (period_count == COUNT_MAX) ? period_count : period_count + 8'd1;
  assign timer_dec  = (timer_left > in_elapsed) ? timer_left - in_elapsed : 16'd0;
  assign is_high    = in_voltage > shutdown_limit;

  always_comb begin
    low_count_next      = low_inc;
    low_flag_next       = low_flag;
    watch_state_next    = watch_state;
    period_count_next   = period_count;
    timer_left_next     = timer_left;
    shutdown_latch_next = shutdown_latch;

    if (is_high) begin
      low_count_next = 8'd0;
      low_flag_next  = 1'b0;
    end else if (low_inc >= low_reads_needed) begin
      low_flag_next = 1'b1;
    end

    if (!watch_state) begin
      // The elapsed time of the confirming check does not count against the new period.
      if (low_flag_next) begin
        timer_left_next  = period_ms;
        watch_state_next = 1'b1;
      end
    end else begin
      timer_left_next = timer_dec;
      if (timer_dec == 16'd0) begin
        if (!low_flag_next) begin
          period_count_next = 8'd0;
          watch_state_next  = 1'b0;
        end else begin
          period_count_next = period_inc;
          if (period_inc >= periods_needed) begin
            shutdown_latch_next = 1'b1;
          end else begin
            timer_left_next = period_ms;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      low_count      <= 8'd0;
      low_flag       <= 1'b0;
      watch_state    <= 1'b0;
      period_count   <= 8'd0;
      timer_left     <= 16'd0;
      shutdown_latch <= 1'b0;
    end else if (advance) begin
      low_count      <= low_count_next;
      low_flag       <= low_flag_next;
      watch_state    <= watch_state_next;
      period_count   <= period_count_next;
      timer_left     <= timer_left_next;
      shutdown_latch <= shutdown_latch_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {5'd0, period_count_next, watch_state_next, low_flag_next,
                  shutdown_latch_next};
    end
  end

  // The latch is only ever set; nothing but reset clears it.
  `LVDC_ASSERT_NEXT(a_latch_sticky, shutdown_latch, shutdown_latch)
  // A confirmed low always rests on at least one counted low reading.
  `LVDC_ASSERT_NOW(a_flag_has_count, low_flag, low_count != 8'd0)
  // Periods are only counted while watching and cleared on the way out.
  `LVDC_ASSERT_NOW(a_periods_in_watch, period_count != 8'd0, watch_state)
  // A running timer means the watch state is active.
  `LVDC_ASSERT_NOW(a_timer_in_watch, timer_left != 16'd0, watch_state)

endmodule

`default_nettype wire
